FILE: rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants for the rounded rectangle coverage block.
// ----------------------------------------------------------------------------
package rrc_pkg;

  // Default coordinate width (screen columns/rows)
  localparam int COORD_BITS_DEF = 12;

  // Pixel / color width
  localparam int COLOR_W = 32;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_CORNER_MASK   = 3'd5,
    REG_FILL_COLOR    = 3'd6
  } cfg_reg_t;

  // Reset value of the corner mask: all four corners rounded
  localparam logic [3:0] CORNER_MASK_RST = 4'hF;

  // Per-beat classification handed to the circle test
  typedef struct packed {
    logic in_rect;  // pixel lies inside the box
    logic corner;   // pixel lies in a rounded corner block
  } rrc_ctl_t;

endpackage

FILE: rtl/rounded_rect_coverage.sv
// ----------------------------------------------------------------------------
// rounded_rect_coverage
// Tests one pixel per clock against a filled rounded rectangle and returns
// the fill color or the background, with a coverage flag.
// ----------------------------------------------------------------------------
//  Channel  Ports                                     Handshake
//  -------  ----------------------------------------  ---------------------------
//  input    in_pixel_x, in_pixel_y, in_background     start && !busy
//  result   out_pixel_out, out_covered                out_valid, one-cycle strobe
//  config   cfg_addr, cfg_wdata                       cfg_we
//
//  One beat in per clock; its result strobe follows four register stages:
//  input, classification, squares, sum/compare into the result register.
//  busy is always low; the receiver cannot stall, so results simply stream.
//  Synchronous active-low reset clears the valid pipe and config registers.
//  Radius clamp is combinational from configuration; r*r is registered.
// ----------------------------------------------------------------------------
module rounded_rect_coverage #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat
  input  logic                              start,
  output logic                              busy,
  input  logic [COORD_BITS-1:0]             in_pixel_x,
  input  logic [COORD_BITS-1:0]             in_pixel_y,
  input  logic [rrc_pkg::COLOR_W-1:0]       in_background,
  // result beat
  output logic                              out_valid,
  output logic [rrc_pkg::COLOR_W-1:0]       out_pixel_out,
  output logic                              out_covered,
  // configuration
  input  logic                              cfg_we,
  input  logic [rrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rrc_pkg::*;

  localparam int CB = COORD_BITS;

  // Configuration registers
  logic signed [CB:0]  left_r;
  logic signed [CB:0]  top_r;
  logic [CB-1:0]       width_r;
  logic [CB-1:0]       height_r;
  logic [CB-1:0]       radius_r;
  logic [3:0]          mask_r;
  logic [COLOR_W-1:0]  fill_r;

  // Derived geometry
  logic [CB-1:0]       rad;
  logic [CB-1:0]       wmr;
  logic [CB-1:0]       hmr;
  logic [2*CB-1:0]     rr_nxt;
  logic [2*CB-1:0]     rr_r;

  // Stage 0: input register
  logic                s0_valid_r;
  logic [CB-1:0]       s0_px_r;
  logic [CB-1:0]       s0_py_r;
  logic [COLOR_W-1:0]  s0_bg_r;

  // Stage 1: classification
  logic signed [CB+1:0] cx;
  logic signed [CB+1:0] cy;
  logic                 in_box;
  logic                 h_lo;
  logic                 h_hi;
  logic                 v_lo;
  logic                 v_hi;
  logic [1:0]           corner_sel;
  logic [CB-1:0]        dx_nxt;
  logic [CB-1:0]        dy_nxt;
  rrc_ctl_t             ctl_nxt;

  logic                 s1_valid_r;
  rrc_ctl_t             s1_ctl_r;
  logic [CB-1:0]        s1_dx_r;
  logic [CB-1:0]        s1_dy_r;
  logic [COLOR_W-1:0]   s1_bg_r;
  logic [COLOR_W-1:0]   s2_bg_r;

  logic                 s2_valid;
  logic                 s2_covered;

  // Result register
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_pixel_r;
  logic                 out_covered_r;

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      radius_r <= '0;
      mask_r   <= CORNER_MASK_RST;
      fill_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RECT_LEFT:     left_r   <= cfg_wdata[CB:0];
        REG_RECT_TOP:      top_r    <= cfg_wdata[CB:0];
        REG_RECT_WIDTH:    width_r  <= cfg_wdata[CB-1:0];
        REG_RECT_HEIGHT:   height_r <= cfg_wdata[CB-1:0];
        REG_CORNER_RADIUS: radius_r <= cfg_wdata[CB-1:0];
        REG_CORNER_MASK:   mask_r   <= cfg_wdata[3:0];
        REG_FILL_COLOR:    fill_r   <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Radius clamped to half width, then half height; far corner block edges
  always_comb begin
    rad = radius_r;
    if (rad > (width_r >> 1))  rad = width_r >> 1;
    if (rad > (height_r >> 1)) rad = height_r >> 1;
    wmr    = width_r - rad;
    hmr    = height_r - rad;
    rr_nxt = {{CB{1'b0}}, rad} * {{CB{1'b0}}, rad};
  end

  // r*r is registered from the clamped radius for the circle compare
  always_ff @(posedge clk) begin
    rr_r <= rr_nxt;
  end

  // Stage 0: capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_px_r <= in_pixel_x;
    s0_py_r <= in_pixel_y;
    s0_bg_r <= in_background;
  end

  // Stage 1: box test, corner selection and offsets from the arc center
  always_comb begin
    cx = $signed({2'b00, s0_px_r}) - $signed({left_r[CB], left_r});
    cy = $signed({2'b00, s0_py_r}) - $signed({top_r[CB], top_r});
    in_box = (cx >= 0) && (cx < $signed({2'b00, width_r}))
          && (cy >= 0) && (cy < $signed({2'b00, height_r}));
    h_lo = cx < $signed({2'b00, rad});
    h_hi = !h_lo && (cx >= $signed({2'b00, wmr}));
    v_lo = cy < $signed({2'b00, rad});
    v_hi = !v_lo && (cy >= $signed({2'b00, hmr}));
    corner_sel = {v_hi, h_hi};
    // left/top: r-1-c ; right/bottom: c-(extent-r)
    dx_nxt = h_lo ? (rad - 1'b1 - cx[CB-1:0]) : (cx[CB-1:0] - wmr);
    dy_nxt = v_lo ? (rad - 1'b1 - cy[CB-1:0]) : (cy[CB-1:0] - hmr);
    ctl_nxt.in_rect = in_box;
    ctl_nxt.corner  = (h_lo || h_hi) && (v_lo || v_hi) && mask_r[corner_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r <= ctl_nxt;
    s1_dx_r  <= dx_nxt;
    s1_dy_r  <= dy_nxt;
    s1_bg_r  <= s0_bg_r;
    s2_bg_r  <= s1_bg_r;
  end

  // Stages 2-3: circle test
  rrc_circle #(
    .COORD_BITS (COORD_BITS)
  ) u_circle (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (s1_valid_r),
    .ctl_i     (s1_ctl_r),
    .dx_i      (s1_dx_r),
    .dy_i      (s1_dy_r),
    .rr_i      (rr_r),
    .valid_o   (s2_valid),
    .covered_o (s2_covered)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_covered_r <= s2_covered;
    out_pixel_r   <= s2_covered ? fill_r : s2_bg_r;
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_covered   = out_covered_r;

endmodule

FILE: rtl/rrc_circle.sv
// ----------------------------------------------------------------------------
// rrc_circle
// Two-stage circle test: squares of the corner offsets are registered, then
// summed and compared against r*r to decide coverage.
// ----------------------------------------------------------------------------
module rrc_circle #(
  parameter int COORD_BITS = rrc_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_i,
  input  rrc_pkg::rrc_ctl_t        ctl_i,
  input  logic [COORD_BITS-1:0]    dx_i,
  input  logic [COORD_BITS-1:0]    dy_i,
  input  logic [2*COORD_BITS-1:0]  rr_i,
  output logic                     valid_o,
  output logic                     covered_o
);
  import rrc_pkg::*;

  localparam int SQ_W = 2 * COORD_BITS;

  logic            valid_r;
  rrc_ctl_t        ctl_r;
  logic [SQ_W-1:0] dx2_r;
  logic [SQ_W-1:0] dy2_r;
  logic [SQ_W:0]   dist_sum;

  // Valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // Squares stage
  always_ff @(posedge clk) begin
    ctl_r <= ctl_i;
    dx2_r <= {{COORD_BITS{1'b0}}, dx_i} * {{COORD_BITS{1'b0}}, dx_i};
    dy2_r <= {{COORD_BITS{1'b0}}, dy_i} * {{COORD_BITS{1'b0}}, dy_i};
  end

  // Sum and compare against r squared
  assign dist_sum  = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign valid_o   = valid_r;
  assign covered_o = ctl_r.in_rect && !(ctl_r.corner && (dist_sum > {1'b0, rr_i}));

endmodule
